[hw/rtl/kale_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed array list engine package
// Shared types and constants for the list controller, datapath and top level.
// ----------------------------------------------------------------------------
package kale_pkg;

	typedef enum logic [1:0] {
		FN_FIND       = 2'd0,
		FN_INS_BEFORE = 2'd1,
		FN_INS_AFTER  = 2'd2,
		FN_REMOVE     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] key;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] position;
		logic [4:0] occupancy;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE    = 2'd0,
		S_COMPARE = 2'd1,
		S_LOCATE  = 2'd2,
		S_APPLY   = 2'd3
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic locate;
		logic apply;
	} cmd_t;

endpackage

[hw/rtl/kale_ctrl.sv]
// ----------------------------------------------------------------------------
// Keyed array list controller
// Sequences each request through compare, locate and apply steps.
// ----------------------------------------------------------------------------
module kale_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output kale_pkg::cmd_t    cmd
);

	kale_pkg::state_t state_q;
	kale_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kale_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		unique case (state_q)
			kale_pkg::S_IDLE: begin
				state_d = start ? kale_pkg::S_COMPARE : kale_pkg::S_IDLE;
			end
			kale_pkg::S_COMPARE: begin
				state_d = kale_pkg::S_LOCATE;
			end
			kale_pkg::S_LOCATE: begin
				state_d = kale_pkg::S_APPLY;
			end
			kale_pkg::S_APPLY: begin
				state_d = kale_pkg::S_IDLE;
			end
			default: begin
				state_d = kale_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			kale_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			kale_pkg::S_COMPARE: begin
				cmd.compare = 1'b1;
			end
			kale_pkg::S_LOCATE: begin
				cmd.locate = 1'b1;
			end
			kale_pkg::S_APPLY: begin
				cmd.apply = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.compare, cmd.locate, cmd.apply}))
		else $error("More than one step commanded at once.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.compare ##1 cmd.locate ##1 cmd.apply)
		else $error("Request steps out of order.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> !busy)
		else $error("Controller still busy after the apply step.");

endmodule

[hw/rtl/kale_datapath.sv]
// ----------------------------------------------------------------------------
// Keyed array list datapath
// Holds the list slots and count, compares all slots against the key, finds
// the first match and shifts entries for insert and remove.
// ----------------------------------------------------------------------------
module kale_datapath #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kale_pkg::cmd_t cmd,
	input  kale_pkg::req_t req,
	output logic           done,
	output kale_pkg::rsp_t rsp
);

	localparam int IDXW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	kale_pkg::req_t            req_q;
	logic [31:0]               store_q [DEPTH];
	logic [CNTW-1:0]           count_q;
	logic [DEPTH-1:0]          match_q;
	logic [IDXW-1:0]           hit_q;
	logic                      found_q;
	logic                      done_q;
	kale_pkg::rsp_t            rsp_q;

	logic [DEPTH-1:0]          match_d;
	logic [DEPTH-1:0]          lowest;
	logic [IDXW-1:0]           hit_d;
	logic                      full;
	logic                      empty;
	logic                      is_insert;
	logic                      do_ins_empty;
	logic                      do_ins;
	logic                      do_rem;
	logic [IDXW-1:0]           tgt;
	kale_pkg::status_t         status_d;
	logic [IDXW-1:0]           pos_d;
	logic [CNTW-1:0]           count_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Compare every occupied slot against the key.
	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cmp
			localparam logic [CNTW-1:0] SLOT_C = CNTW'(g);
			assign match_d[g] = (store_q[g] == req_q.key) && (SLOT_C < count_q);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_q <= match_d;
		end
	end

	// First match: isolate the lowest set bit, then encode it.
	assign lowest = match_q & (~match_q + DEPTH'(1));

	always_comb begin
		hit_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lowest[i]) begin
				hit_d = hit_d | IDXW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.locate) begin
			hit_q   <= hit_d;
			found_q <= |match_q;
		end
	end

	assign full      = (count_q == CNTW'(DEPTH));
	assign empty     = (count_q == '0);
	assign is_insert = (req_q.func == kale_pkg::FN_INS_BEFORE)
		|| (req_q.func == kale_pkg::FN_INS_AFTER);
	assign tgt       = hit_q + IDXW'(req_q.func == kale_pkg::FN_INS_AFTER);

	always_comb begin
		status_d     = kale_pkg::ST_DONE;
		pos_d        = '0;
		count_d      = count_q;
		do_ins_empty = 1'b0;
		do_ins       = 1'b0;
		do_rem       = 1'b0;
		if (is_insert) begin
			priority if (full) begin
				status_d = kale_pkg::ST_FULL;
			end else if (empty) begin
				do_ins_empty = 1'b1;
				count_d      = CNTW'(1);
			end else if (!found_q) begin
				status_d = kale_pkg::ST_MISSING;
			end else begin
				do_ins  = 1'b1;
				pos_d   = tgt;
				count_d = count_q + CNTW'(1);
			end
		end else begin
			priority if (empty) begin
				status_d = kale_pkg::ST_EMPTY;
			end else if (!found_q) begin
				status_d = kale_pkg::ST_MISSING;
			end else begin
				pos_d = hit_q;
				if (req_q.func == kale_pkg::FN_REMOVE) begin
					do_rem  = 1'b1;
					count_d = count_q - CNTW'(1);
				end
			end
		end
	end

	// Per-slot update: shift up behind the insert point, down behind the
	// removed entry.
	generate
		for (g = 0; g < DEPTH; g++) begin : g_slot
			localparam logic [IDXW-1:0] SLOT_I = IDXW'(g);
			localparam logic [CNTW-1:0] SLOT_C = CNTW'(g);
			localparam logic [CNTW-1:0] SLOT_N = CNTW'(g + 1);
			logic [31:0] up_src;
			logic [31:0] down_src;
			logic        wr_en;
			logic [31:0] wr_data;

			if (g > 0) begin : g_up
				assign up_src = store_q[g-1];
			end else begin : g_up0
				assign up_src = '0;
			end
			if (g < DEPTH - 1) begin : g_dn
				assign down_src = store_q[g+1];
			end else begin : g_dn_last
				assign down_src = '0;
			end

			always_comb begin
				wr_en   = 1'b0;
				wr_data = down_src;
				if (cmd.apply) begin
					priority if (do_ins_empty && (g == 0)) begin
						wr_en   = 1'b1;
						wr_data = req_q.new_value;
					end else if (do_ins && (SLOT_I == tgt)) begin
						wr_en   = 1'b1;
						wr_data = req_q.new_value;
					end else if (do_ins && (SLOT_I > tgt) && (SLOT_C <= count_q)) begin
						wr_en   = 1'b1;
						wr_data = up_src;
					end else if (do_rem && (SLOT_I >= hit_q) && (SLOT_N < count_q)) begin
						wr_en   = 1'b1;
						wr_data = down_src;
					end else begin
						wr_en = 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (wr_en) begin
					store_q[g] <= wr_data;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.apply;
			if (cmd.apply) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			rsp_q.status    <= status_d;
			rsp_q.position  <= 4'(pos_d);
			rsp_q.occupancy <= 5'(count_d);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("Entry count beyond the list depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && (status_d != kale_pkg::ST_DONE)) |=> $stable(count_q))
		else $error("Rejected request changed the entry count.");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.apply))
		else $error("Result strobe without an apply step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> $onehot0({do_ins_empty, do_ins, do_rem}))
		else $error("Conflicting list updates.");

endmodule

[hw/rtl/keyed_array_list_engine.sv]
// ----------------------------------------------------------------------------
// Keyed array list engine
// Ordered list of signed 32-bit values with find, insert and remove by key.
// ----------------------------------------------------------------------------
//  Channel   Signals               Transfer
//  request   start, busy, req      start high and busy low at a rising edge
//  result    done, rsp             done high for one cycle, always taken
//
// An accepted request passes through its steps in order: compare all slots,
// encode the first match, then update the slots and count. done rises in
// the cycle after the update, when busy has already fallen, so the next
// request may be accepted in that same cycle. Reset clears the entry count;
// slot contents are unread until written. The receiver cannot stall
// results, so none are ever held back.
// ----------------------------------------------------------------------------
module keyed_array_list_engine #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  kale_pkg::req_t req,
	output logic           done,
	output kale_pkg::rsp_t rsp
);

	kale_pkg::cmd_t cmd;

	kale_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	kale_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

[bench/tb_keyed_array_list_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed array list engine testbench
// Runs a directed sequence through the empty, full, duplicate and first and
// last slot cases of the list, then 950 random requests whose keys are
// mostly taken from the list itself. Each result is compared with a typed
// directed value, if given, else with a list predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_keyed_array_list_engine;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_ITEMS = 950;
	localparam int MAX_PRINTED  = 200;

	typedef struct {
		kale_pkg::req_t rq;
		bit             typed;
		kale_pkg::rsp_t want;
	} list_step_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	kale_pkg::req_t req;
	logic           done;
	kale_pkg::rsp_t rsp;

	// Expected result typed into the directed table, travelling beside req.
	logic           step_typed;
	kale_pkg::rsp_t step_want;

	logic signed [31:0] list_vals [LIST_DEPTH];
	int                 list_len;
	kale_pkg::rsp_t     expected_rsps [$];
	list_step_t         directed_steps [$];
	int                 fault_count;
	bit                 growing;

	keyed_array_list_engine #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fault_count++;
		if (fault_count <= MAX_PRINTED) begin
			$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		end
	endtask

	function automatic kale_pkg::rsp_t apply_request(input kale_pkg::req_t r);
		kale_pkg::rsp_t res;
		int             hit;
		int             slot;
		res.status   = kale_pkg::ST_DONE;
		res.position = '0;
		hit          = -1;
		for (int i = 0; i < list_len; i++) begin
			if (hit < 0 && list_vals[i] == r.key) begin
				hit = i;
			end
		end
		case (r.func)
			kale_pkg::FN_FIND: begin
				if (list_len == 0) begin
					res.status = kale_pkg::ST_EMPTY;
				end else if (hit < 0) begin
					res.status = kale_pkg::ST_MISSING;
				end else begin
					res.position = hit[3:0];
				end
			end
			kale_pkg::FN_INS_BEFORE, kale_pkg::FN_INS_AFTER: begin
				if (list_len >= LIST_DEPTH) begin
					res.status = kale_pkg::ST_FULL;
				end else if (list_len == 0) begin
					list_vals[0] = r.new_value;
					list_len     = 1;
				end else if (hit < 0) begin
					res.status = kale_pkg::ST_MISSING;
				end else begin
					slot = (r.func == kale_pkg::FN_INS_AFTER) ? hit + 1 : hit;
					for (int i = list_len; i > slot; i--) begin
						list_vals[i] = list_vals[i - 1];
					end
					list_vals[slot] = r.new_value;
					list_len++;
					res.position = slot[3:0];
				end
			end
			default: begin
				if (list_len == 0) begin
					res.status = kale_pkg::ST_EMPTY;
				end else if (hit < 0) begin
					res.status = kale_pkg::ST_MISSING;
				end else begin
					for (int i = hit; i + 1 < list_len; i++) begin
						list_vals[i] = list_vals[i + 1];
					end
					list_len--;
					res.position = hit[3:0];
				end
			end
		endcase
		res.occupancy = list_len[4:0];
		return res;
	endfunction

	always @(posedge clk) begin
		kale_pkg::rsp_t predicted;
		kale_pkg::rsp_t want;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("outstanding request", 0, 1);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status) begin
					report_mismatch("status", rsp.status, want.status);
				end
				if (rsp.position !== want.position) begin
					report_mismatch("position", rsp.position, want.position);
				end
				if (rsp.occupancy !== want.occupancy) begin
					report_mismatch("occupancy", rsp.occupancy, want.occupancy);
				end
			end
		end
		if (arst_n && start && !busy) begin
			predicted = apply_request(req);
			expected_rsps.push_back(step_typed ? step_want : predicted);
		end
	end

	task automatic issue(input kale_pkg::req_t r, input bit typed, input kale_pkg::rsp_t want);
		start      <= 1'b1;
		req        <= r;
		step_typed <= typed;
		step_want  <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		while (expected_rsps.size() != 0) @(posedge clk);
	endtask

	function automatic void add_step(input kale_pkg::func_t f, input logic [31:0] k,
			input logic [31:0] v, input bit typed, input kale_pkg::status_t s,
			input int p, input int o);
		list_step_t st;
		st.rq.func           = f;
		st.rq.key            = k;
		st.rq.new_value      = v;
		st.typed             = typed;
		st.want.status       = s;
		st.want.position     = p[3:0];
		st.want.occupancy    = o[4:0];
		directed_steps.push_back(st);
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return 32'h0000_0001;
			default: return 32'h0000_0005;
		endcase
	endfunction

	function automatic kale_pkg::req_t random_request();
		kale_pkg::req_t r;
		int             pick;
		pick = $urandom_range(0, 99);
		if (list_len >= LIST_DEPTH && $urandom_range(0, 3) == 0) begin
			growing = 1'b0;
		end else if (list_len == 0 && $urandom_range(0, 3) == 0) begin
			growing = 1'b1;
		end
		if (pick < 20) begin
			r.func = kale_pkg::FN_FIND;
		end else if (pick < (growing ? 55 : 35)) begin
			r.func = kale_pkg::FN_INS_BEFORE;
		end else if (pick < (growing ? 90 : 50)) begin
			r.func = kale_pkg::FN_INS_AFTER;
		end else begin
			r.func = kale_pkg::FN_REMOVE;
		end
		if (list_len > 0 && $urandom_range(0, 9) < 8) begin
			r.key = list_vals[$urandom_range(0, list_len - 1)];
		end else if ($urandom_range(0, 2) == 0) begin
			r.key = edge_value();
		end else begin
			r.key = $urandom;
		end
		r.new_value = ($urandom_range(0, 2) == 0) ? edge_value() : $urandom;
		return r;
	endfunction

	initial begin
		int         burst_left;
		list_step_t st;
		arst_n        = 1'b0;
		start         = 1'b0;
		req           = '0;
		step_typed    = 1'b0;
		step_want     = '0;
		list_len      = 0;
		fault_count   = 0;
		growing       = 1'b1;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			list_vals[i] = '0;
		end

		add_step(kale_pkg::FN_FIND, 32'h0000_0000, 32'h0000_0000,
			1, kale_pkg::ST_EMPTY, 0, 0);
		add_step(kale_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000,
			1, kale_pkg::ST_EMPTY, 0, 0);
		add_step(kale_pkg::FN_INS_AFTER, 32'h5555_5555, 32'hFFFF_FFFF,
			1, kale_pkg::ST_DONE, 0, 1);
		add_step(kale_pkg::FN_FIND, 32'hFFFF_FFFF, 32'h0000_0000,
			1, kale_pkg::ST_DONE, 0, 1);
		add_step(kale_pkg::FN_FIND, 32'h0000_0000, 32'h0000_0000,
			1, kale_pkg::ST_MISSING, 0, 1);
		add_step(kale_pkg::FN_INS_AFTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			1, kale_pkg::ST_DONE, 1, 2);
		add_step(kale_pkg::FN_INS_BEFORE, 32'hFFFF_FFFF, 32'h8000_0000,
			1, kale_pkg::ST_DONE, 0, 3);
		add_step(kale_pkg::FN_INS_BEFORE, 32'h7FFF_FFFF, 32'h0000_0000,
			0, kale_pkg::ST_DONE, 0, 0);
		add_step(kale_pkg::FN_INS_BEFORE, 32'h0000_3039, 32'h0000_0007,
			1, kale_pkg::ST_MISSING, 0, 4);
		add_step(kale_pkg::FN_REMOVE, 32'h8000_0000, 32'h0000_0000,
			0, kale_pkg::ST_DONE, 0, 0);
		add_step(kale_pkg::FN_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000,
			0, kale_pkg::ST_DONE, 0, 0);
		// Each new value lands just behind the zero, so the first one ends in the last slot.
		for (int i = 0; i < 14; i++) begin
			add_step(kale_pkg::FN_INS_AFTER, 32'h0000_0000,
				(i == 3) ? 32'hFFFF_FFFF : {i[15:0], 16'hA5C3},
				0, kale_pkg::ST_DONE, 0, 0);
		end
		add_step(kale_pkg::FN_INS_BEFORE, 32'h1357_2468, 32'h0000_0001,
			1, kale_pkg::ST_FULL, 0, 16);
		add_step(kale_pkg::FN_FIND, 32'h0000_A5C3, 32'h0000_0000,
			0, kale_pkg::ST_DONE, 0, 0);
		add_step(kale_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000,
			0, kale_pkg::ST_DONE, 0, 0);
		add_step(kale_pkg::FN_INS_AFTER, 32'h0000_A5C3, 32'h0000_0002,
			0, kale_pkg::ST_DONE, 0, 0);
		add_step(kale_pkg::FN_FIND, 32'hFFFF_FFFF, 32'h0000_0000,
			0, kale_pkg::ST_DONE, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			st = directed_steps[i];
			issue(st.rq, st.typed, st.want);
		end

		start <= 1'b0;
		@(posedge clk);
		wait_drained();

		burst_left = $urandom_range(1, 20);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 240 == 239) begin
				start <= 1'b0;
				@(posedge clk);
				wait_drained();
			end else if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 20);
			end
			issue(random_request(), 1'b0, '0);
			if (burst_left > 0) begin
				burst_left--;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (10) @(posedge clk);
		if (fault_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/kale_pkg.sv
hw/rtl/kale_ctrl.sv
hw/rtl/kale_datapath.sv
hw/rtl/keyed_array_list_engine.sv
bench/tb_keyed_array_list_engine.sv
